// ===== src/mpfm_pkg.sv =====
// Package: shared types, codes and constants of the pipe pool manager.
package mpfm_pkg;

  localparam int unsigned NumPipesDef = 16;
  localparam int unsigned BufDepthDef = 4096;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_ADDREF = 3'd1,
    ACT_DROP   = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_READ   = 3'd4,
    ACT_QUERY  = 3'd5,
    ACT_RSV6   = 3'd6,
    ACT_RSV7   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BROKEN    = 3'd2,
    ST_FULL      = 3'd3,
    ST_EOF       = 3'd4,
    ST_BLOCK     = 3'd5,
    ST_NONE_FREE = 3'd6,
    ST_RSV7      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MEM  = 2'd1,
    BK_OUT  = 2'd2
  } back_state_e;

  // Decoded request passed from the front to the back.
  typedef struct packed {
    action_e    action;
    logic [3:0] pipe_sel;
    logic       end_is_write;
    logic [7:0] data_byte;
    logic       request_last;
    logic       known;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] pipe_given;
    logic [7:0] data_out;
    logic       readable;
    logic       wake_reader;
    logic       pipe_freed;
    logic       last_echo;
  } rsp_t;

endpackage

// ===== src/mpfm_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
interface mpfm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] pipe_sel;
  logic       end_is_write;
  logic [7:0] data_byte;
  logic       request_last;
  modport source (output valid, action, pipe_sel, end_is_write, data_byte, request_last,
                  input ready);
  modport sink   (input valid, action, pipe_sel, end_is_write, data_byte, request_last,
                  output ready);
endinterface

interface mpfm_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] pipe_given;
  logic [7:0] data_out;
  logic       readable;
  logic       wake_reader;
  logic       pipe_freed;
  logic       last_echo;
  modport source (output valid, status, pipe_given, data_out, readable, wake_reader,
                  pipe_freed, last_echo, input ready);
  modport sink   (input valid, status, pipe_given, data_out, readable, wake_reader,
                  pipe_freed, last_echo, output ready);
endinterface

// ===== src/mpfm_front.sv =====
// Front end: accept requests, classify the action, queue them for the back end.
module mpfm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpfm_req_if.sink          req,
  output mpfm_pkg::req_t    q_data_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);

  localparam int unsigned PtrW = $clog2(mpfm_pkg::QueueDepth);

  mpfm_pkg::req_t              fifo_q [mpfm_pkg::QueueDepth];
  logic [PtrW-1:0]             wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]               cnt_q;
  logic                        push;
  mpfm_pkg::req_t              in_req;

  assign req.ready = (cnt_q != PtrW'(0) + (PtrW+1)'(mpfm_pkg::QueueDepth));
  assign push      = req.valid && req.ready;

  // Classify the incoming action.
  always_comb begin
    in_req.action       = mpfm_pkg::action_e'(req.action);
    in_req.pipe_sel     = req.pipe_sel;
    in_req.end_is_write = req.end_is_write;
    in_req.data_byte    = req.data_byte;
    in_req.request_last = req.request_last;
    in_req.known        = (req.action <= 3'(mpfm_pkg::ACT_QUERY));
  end

  // Store the transfer in the queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_req;
    end
  end

  // Advance queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (q_pop_i) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = fifo_q[rd_ptr_q];

endmodule

// ===== src/mpfm_back.sv =====
// Back end: per-pipe bookkeeping, byte store access and response register.
module mpfm_back #(
  parameter int unsigned NumPipes = mpfm_pkg::NumPipesDef,
  parameter int unsigned BufDepth = mpfm_pkg::BufDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpfm_pkg::req_t    q_data_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  mpfm_rsp_if.source        rsp
);

  localparam int unsigned CurW  = (BufDepth > 2) ? $clog2(BufDepth) : 1;
  localparam int unsigned FillW = $clog2(BufDepth + 1);
  localparam int unsigned PW    = (NumPipes > 1) ? $clog2(NumPipes) : 1;
  localparam int unsigned MemD  = NumPipes * (2 ** CurW);
  localparam int unsigned AddrW = PW + CurW;

  logic [NumPipes-1:0] in_use_q, parked_q;
  logic [CurW-1:0]     cur_q  [NumPipes];
  logic [FillW-1:0]    fill_q [NumPipes];
  logic [7:0]          rref_q [NumPipes];
  logic [7:0]          wref_q [NumPipes];
  logic [7:0]          mem_q  [MemD];

  mpfm_pkg::back_state_e state_q, state_d;
  mpfm_pkg::rsp_t        rsp_q, rsp_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [7:0]            rd_data_q;

  logic [PW-1:0]    p;
  logic             valid_pipe;
  logic             take;
  logic [CurW-1:0]  wpos;
  logic [AddrW-1:0] maddr;
  logic             mem_we, mem_re;
  logic [PW-1:0]    free_idx;
  logic             free_found;
  logic [7:0]       rref_n, wref_n;
  logic [CurW:0]    wsum;

  assign p          = PW'(q_data_i.pipe_sel);
  assign valid_pipe = ({28'd0, q_data_i.pipe_sel} < NumPipes) && in_use_q[p];
  assign take       = (state_q == mpfm_pkg::BK_IDLE) && q_valid_i;
  assign q_pop_o    = take;

  // Find the lowest free pipe.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NumPipes - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = PW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Ring position of the next write, wrapping at the buffer depth.
  always_comb begin
    wsum = {1'b0, cur_q[p]} + (CurW+1)'(fill_q[p]);
    if (wsum >= (CurW+1)'(BufDepth)) wsum = wsum - (CurW+1)'(BufDepth);
    wpos = wsum[CurW-1:0];
  end

  // Decode the action and compute the state update and response.
  always_comb begin
    rsp_d      = rsp_q;
    rd_pend_d  = rd_pend_q;
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    maddr      = {p, cur_q[p]};
    rref_n     = rref_q[p];
    wref_n     = wref_q[p];
    case (state_q)
      mpfm_pkg::BK_IDLE: begin
        if (take) begin
          rsp_d           = '0;
          rsp_d.last_echo = q_data_i.request_last;
          rd_pend_d       = 1'b0;
          state_d         = mpfm_pkg::BK_OUT;
          if (q_data_i.action == mpfm_pkg::ACT_ALLOC) begin
            if (free_found) rsp_d.pipe_given = 4'(free_idx);
            else rsp_d.status = mpfm_pkg::ST_NONE_FREE;
          end else if (!q_data_i.known || !valid_pipe) begin
            rsp_d.status   = mpfm_pkg::ST_INVALID;
            rsp_d.readable = (q_data_i.action == mpfm_pkg::ACT_QUERY);
          end else begin
            case (q_data_i.action)
              mpfm_pkg::ACT_DROP: begin
                if (q_data_i.end_is_write) begin
                  if (wref_n != 8'd0) wref_n = wref_n - 8'd1;
                  if (wref_n == 8'd0 && parked_q[p]) rsp_d.wake_reader = 1'b1;
                end else if (rref_n != 8'd0) begin
                  rref_n = rref_n - 8'd1;
                end
                rsp_d.pipe_freed = (rref_n == 8'd0) && (wref_n == 8'd0);
              end
              mpfm_pkg::ACT_WRITE: begin
                if (rref_q[p] == 8'd0) rsp_d.status = mpfm_pkg::ST_BROKEN;
                else if (fill_q[p] >= FillW'(BufDepth)) rsp_d.status = mpfm_pkg::ST_FULL;
                else begin
                  mem_we            = 1'b1;
                  maddr             = {p, wpos};
                  rsp_d.wake_reader = parked_q[p];
                end
              end
              mpfm_pkg::ACT_READ: begin
                if (fill_q[p] != '0) begin
                  mem_re    = 1'b1;
                  rd_pend_d = 1'b1;
                  state_d   = mpfm_pkg::BK_MEM;
                end else if (wref_q[p] == 8'd0) rsp_d.status = mpfm_pkg::ST_EOF;
                else rsp_d.status = mpfm_pkg::ST_BLOCK;
              end
              mpfm_pkg::ACT_QUERY: begin
                rsp_d.readable = (fill_q[p] != '0) || (wref_q[p] == 8'd0);
              end
              default: ;
            endcase
          end
        end
      end
      mpfm_pkg::BK_MEM: begin
        rsp_d.data_out = rd_data_q;
        state_d        = mpfm_pkg::BK_OUT;
      end
      mpfm_pkg::BK_OUT: begin
        if (rsp.ready) state_d = mpfm_pkg::BK_IDLE;
      end
      default: state_d = mpfm_pkg::BK_IDLE;
    endcase
  end

  // Byte store with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[maddr] <= q_data_i.data_byte;
    if (mem_re) rd_data_q <= mem_q[maddr];
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Per-pipe counters and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpfm_pkg::BK_IDLE;
      rd_pend_q <= 1'b0;
      in_use_q  <= '0;
      parked_q  <= '0;
      for (int i = 0; i < NumPipes; i++) begin
        cur_q[i]  <= '0;
        fill_q[i] <= '0;
        rref_q[i] <= '0;
        wref_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      if (take) begin
        if (q_data_i.action == mpfm_pkg::ACT_ALLOC) begin
          if (free_found) begin
            in_use_q[free_idx] <= 1'b1;
            parked_q[free_idx] <= 1'b0;
            cur_q[free_idx]    <= '0;
            fill_q[free_idx]   <= '0;
            rref_q[free_idx]   <= 8'd1;
            wref_q[free_idx]   <= 8'd1;
          end
        end else if (q_data_i.known && valid_pipe) begin
          case (q_data_i.action)
            mpfm_pkg::ACT_ADDREF: begin
              if (q_data_i.end_is_write) begin
                if (wref_q[p] != 8'hff) wref_q[p] <= wref_q[p] + 8'd1;
              end else if (rref_q[p] != 8'hff) rref_q[p] <= rref_q[p] + 8'd1;
            end
            mpfm_pkg::ACT_DROP: begin
              rref_q[p] <= rref_n;
              wref_q[p] <= wref_n;
              if (rsp_d.wake_reader) parked_q[p] <= 1'b0;
              if (rsp_d.pipe_freed) begin
                in_use_q[p] <= 1'b0;
                parked_q[p] <= 1'b0;
              end
            end
            mpfm_pkg::ACT_WRITE: begin
              if (mem_we) begin
                fill_q[p]   <= fill_q[p] + FillW'(1);
                parked_q[p] <= 1'b0;
              end
            end
            mpfm_pkg::ACT_READ: begin
              if (mem_re) begin
                fill_q[p] <= fill_q[p] - FillW'(1);
                if ({1'b0, cur_q[p]} == (CurW+1)'(BufDepth - 1)) cur_q[p] <= '0;
                else cur_q[p] <= cur_q[p] + CurW'(1);
              end else if (rsp_d.status == mpfm_pkg::ST_BLOCK) begin
                parked_q[p] <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign rsp.valid       = (state_q == mpfm_pkg::BK_OUT);
  assign rsp.status      = rsp_q.status;
  assign rsp.pipe_given  = rsp_q.pipe_given;
  assign rsp.data_out    = rsp_q.data_out;
  assign rsp.readable    = rsp_q.readable;
  assign rsp.wake_reader = rsp_q.wake_reader;
  assign rsp.pipe_freed  = rsp_q.pipe_freed;
  assign rsp.last_echo   = rsp_q.last_echo;

endmodule

// ===== src/multi_pipe_fifo_manager_core.sv =====
// Top level: pool of byte pipes, each a ring buffer with reference counts.
//
// Usage: requests enter on the req channel (action, pipe_sel, end_is_write,
// data_byte, request_last) and each gives exactly one response on the rsp
// channel (status, pipe_given, data_out, readable, wake_reader, pipe_freed,
// last_echo), in order. A transfer happens when valid and ready are high.
// A two-entry request queue lets the sender keep going while the back end
// works or the receiver stalls.
// A request waits in the queue until the back end is idle; reads also pass
// through the registered byte-store read. The response is then held in its
// output register until taken.
// The back end handles one item at a time through its response register:
// it takes no new request until the response to the last one is taken.
// Reset: all pipes free, counts and cursors zero; the byte store needs no
// clearing since only written bytes are ever read.
// A stalled receiver holds the response; the queue then fills and req.ready
// drops.
module multi_pipe_fifo_manager_core #(
  parameter int unsigned NumPipes = mpfm_pkg::NumPipesDef,
  parameter int unsigned BufDepth = mpfm_pkg::BufDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpfm_req_if.sink   req,
  mpfm_rsp_if.source rsp
);

  mpfm_pkg::req_t q_data;
  logic           q_valid, q_pop;

  mpfm_front u_front (
    .clk_i, .rst_ni, .req,
    .q_data_o(q_data), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  mpfm_back #(.NumPipes(NumPipes), .BufDepth(BufDepth)) u_back (
    .clk_i, .rst_ni,
    .q_data_i(q_data), .q_valid_i(q_valid), .q_pop_o(q_pop), .rsp
  );

endmodule
